// ===== sv/tcw_pkg.sv =====
// tcw_pkg: screen geometry, cell constants, operation codes and the word
// types shared by the text console writer. Depends on nothing.

package tcw_pkg;

   // Screen geometry
   localparam int ROWS   = 25;
   localparam int COLS   = 80;
   localparam int CELLS  = ROWS * COLS;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   // Cell contents
   localparam int          CHAR_W     = 8;
   localparam logic [7:0]  ATTR_WHITE = 8'h0F;
   localparam logic [7:0]  BLANK_CHAR = 8'h20;
   localparam logic [7:0]  NEWLINE    = 8'h0A;

   typedef enum logic [1:0] {
      OP_STREAM = 2'd0,
      OP_PUT    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_COPY,
      ST_BLANK
   } fsm_state_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  char_code;
      logic [7:0]  target_row;
      logic [7:0]  target_col;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [4:0]  cur_row;
      logic [6:0]  cur_col;
      logic        out_of_range;
      logic        scrolled;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic    valid;
      rsp_type word;
   } done_type;

endpackage

// ===== sv/text_console_writer.sv =====
// text_console_writer: top level of the text-mode screen store with scroll.
// Depends on tcw_pkg, tcw_ram and tcw_seq.
//
//   channel   ports                       handshake
//   request   start, busy, req_word       taken when start && !busy
//   result    rsp_strobe, rsp_word        one cycle per word, no back-pressure
//
// Put, stream without scroll and out-of-range read pass from acceptance through
// the execute state and the output register to the strobe; an in-range read
// adds the read state for the RAM read. Scroll walks the store one cell a
// cycle through the single write port of the screen RAM; clear blanks it all.
// Reset clears the cursor, sequencer and result strobe; screen cells are
// undefined until written. The receiver cannot stall: rsp_strobe is high for
// one cycle, busy stays low while it is shown so the next word can be taken.

module text_console_writer (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tcw_pkg::req_type req_word,
   output logic             rsp_strobe,
   output tcw_pkg::rsp_type rsp_word
);

   tcw_pkg::mem_req_type           mem;
   tcw_pkg::done_type              done;
   logic [tcw_pkg::CHAR_W-1:0]     rd_data;

   logic                           rsp_strobe_ff, rsp_strobe_in;
   tcw_pkg::rsp_type               rsp_word_ff, rsp_word_in;

   // Sequencer: cursor, operation decode, scroll and clear sweeps
   tcw_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_word (req_word),
      .rd_data  (rd_data),
      .busy     (busy),
      .mem      (mem),
      .done     (done)
   );

   // Screen store: character byte per cell, attribute is fixed
   tcw_ram #(
      .WIDTH (tcw_pkg::CHAR_W),
      .DEPTH (tcw_pkg::CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data)
   );

   // Output register: hold the finished word for exactly one cycle
   assign rsp_strobe_in = done.valid;
   assign rsp_word_in   = done.word;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without work in progress");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.cur_col < 7'(tcw_pkg::COLS)))
      else $error("cursor column off screen");

endmodule

// ===== sv/tcw_ram.sv =====
// tcw_ram: generic single-clock RAM, one write port and one read port with
// registered read data. Depends on nothing.

module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tcw_seq.sv =====
// tcw_seq: operation sequencer of the text console writer. Holds the cursor,
// drives the screen RAM and sweeps it for scroll and clear. Uses tcw_pkg.

module tcw_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  tcw_pkg::req_type             req_word,
   input  logic [tcw_pkg::CHAR_W-1:0]   rd_data,
   output logic                         busy,
   output tcw_pkg::mem_req_type         mem,
   output tcw_pkg::done_type            done
);

   tcw_pkg::fsm_state_type           state_ff, state_in;
   tcw_pkg::req_type                 req_ff, req_in;
   logic [tcw_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [tcw_pkg::COL_W-1:0]        col_ff, col_in;
   logic [tcw_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                             scr_ff, scr_in;

   logic [tcw_pkg::ADDR_W-1:0]       cur_addr;
   logic [tcw_pkg::ADDR_W-1:0]       tgt_addr;
   logic                             tgt_inside;
   logic                             is_newline;
   logic                             at_row_end;
   logic                             at_bottom;

   assign cur_addr = tcw_pkg::ADDR_W'(row_ff) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
                   + tcw_pkg::ADDR_W'(col_ff);
   assign tgt_addr = tcw_pkg::ADDR_W'(req_ff.target_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
                   + tcw_pkg::ADDR_W'(req_ff.target_col);
   assign tgt_inside = (req_ff.target_row < 8'(tcw_pkg::ROWS))
                    && (req_ff.target_col < 8'(tcw_pkg::COLS));
   assign is_newline = (req_ff.char_code == tcw_pkg::NEWLINE);
   assign at_row_end = (col_ff == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));
   assign at_bottom  = (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         cnt_ff   <= '0;
         scr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         cnt_ff   <= cnt_in;
         scr_ff   <= scr_in;
      end
      req_ff <= req_in;
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      cnt_in   = cnt_ff;
      scr_in   = scr_ff;
      mem      = '0;
      done     = '0;
      busy     = (state_ff != tcw_pkg::ST_IDLE);

      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (start) begin
               req_in   = req_word;
               state_in = tcw_pkg::ST_EXEC;
            end
         end

         tcw_pkg::ST_EXEC: begin
            state_in = tcw_pkg::ST_IDLE;
            unique case (req_ff.operation)
               tcw_pkg::OP_STREAM: begin
                  if (!is_newline) begin
                     mem.wr_en   = 1'b1;
                     mem.wr_addr = cur_addr;
                     mem.wr_data = req_ff.char_code;
                  end
                  if (is_newline || at_row_end) begin
                     col_in = '0;
                     if (at_bottom) begin
                        // cursor stays on the last row; walk the store
                        cnt_in   = '0;
                        scr_in   = 1'b1;
                        state_in = tcw_pkg::ST_COPY;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  if (state_in == tcw_pkg::ST_IDLE) begin
                     done.valid = 1'b1;
                  end
               end
               tcw_pkg::OP_PUT: begin
                  mem.wr_en   = tgt_inside;
                  mem.wr_addr = tgt_addr;
                  mem.wr_data = req_ff.char_code;
                  done.valid  = 1'b1;
                  done.word.out_of_range = !tgt_inside;
               end
               tcw_pkg::OP_CLEAR: begin
                  row_in   = '0;
                  col_in   = '0;
                  cnt_in   = '0;
                  scr_in   = 1'b0;
                  state_in = tcw_pkg::ST_BLANK;
               end
               tcw_pkg::OP_READ: begin
                  if (tgt_inside) begin
                     mem.rd_en   = 1'b1;
                     mem.rd_addr = tgt_addr;
                     state_in    = tcw_pkg::ST_READ;
                  end else begin
                     done.valid = 1'b1;
                     done.word.out_of_range = 1'b1;
                  end
               end
               default: begin
                  state_in = tcw_pkg::ST_IDLE;
               end
            endcase
         end

         tcw_pkg::ST_READ: begin
            done.valid           = 1'b1;
            done.word.cell_value = {tcw_pkg::ATTR_WHITE, rd_data};
            state_in             = tcw_pkg::ST_IDLE;
         end

         tcw_pkg::ST_COPY: begin
            // read one row ahead, write the previous read back one row up
            if (cnt_ff != tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLS)) begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = tcw_pkg::ADDR_W'(cnt_ff + tcw_pkg::CNT_W'(tcw_pkg::COLS));
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               state_in = tcw_pkg::ST_BLANK;
            end
            if (cnt_ff != '0) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = tcw_pkg::ADDR_W'(cnt_ff - 1'b1);
               mem.wr_data = rd_data;
            end
         end

         tcw_pkg::ST_BLANK: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = tcw_pkg::ADDR_W'(cnt_ff);
            mem.wr_data = tcw_pkg::BLANK_CHAR;
            if (cnt_ff == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
               done.valid         = 1'b1;
               done.word.scrolled = scr_ff;
               state_in           = tcw_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase

      done.word.cur_row = 5'(row_in);
      done.word.cur_col = 7'(col_in);
   end

endmodule

// ===== tb/tcw_checker.sv =====
// tcw_checker: watches the request and result channels of the text console
// writer, predicts each result word from its own screen copy and compares.
// Depends on tcw_pkg.

module tcw_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  tcw_pkg::req_type req_word,
   input  logic             rsp_strobe,
   input  tcw_pkg::rsp_type rsp_word,
   output int               failures,
   output int               pending,
   output int               checked,
   output int               scrolls,
   output int               off_screen
);

   import tcw_pkg::*;

   logic [15:0] screen [CELLS];
   logic [4:0]  row_at;
   logic [6:0]  col_at;
   rsp_type     expected_words [$];
   int          fail_count;
   int          checked_count;
   int          scroll_count;
   int          off_count;

   task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
      fail_count++;
      if (fail_count <= 50)
         $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
   endtask

   // Move to column 0 of the next row; past the bottom row, roll the screen up.
   task automatic advance_line(output logic rolled);
      col_at = '0;
      rolled = 1'b0;
      if (row_at == ROWS - 1) begin
         for (int i = 0; i < (ROWS - 1) * COLS; i++)
            screen[i] = screen[i + COLS];
         for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
            screen[i] = {ATTR_WHITE, BLANK_CHAR};
         rolled = 1'b1;
      end else begin
         row_at++;
      end
   endtask

   task automatic predict_word(input req_type w);
      rsp_type e;
      logic    in_view;
      logic    rolled;
      int      idx;
      e = '0;
      rolled = 1'b0;
      in_view = (w.target_row < ROWS) && (w.target_col < COLS);
      idx = int'(w.target_row) * COLS + int'(w.target_col);
      case (w.operation)
         OP_STREAM: begin
            if (w.char_code == NEWLINE) begin
               advance_line(rolled);
            end else begin
               screen[int'(row_at) * COLS + int'(col_at)] = {ATTR_WHITE, w.char_code};
               if (col_at == COLS - 1)
                  advance_line(rolled);
               else
                  col_at++;
            end
         end
         OP_PUT: begin
            if (in_view)
               screen[idx] = {ATTR_WHITE, w.char_code};
            else
               e.out_of_range = 1'b1;
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen[i] = {ATTR_WHITE, BLANK_CHAR};
            row_at = '0;
            col_at = '0;
         end
         default: begin
            if (in_view)
               e.cell_value = screen[idx];
            else
               e.out_of_range = 1'b1;
         end
      endcase
      e.scrolled = rolled;
      e.cur_row  = row_at;
      e.cur_col  = col_at;
      scroll_count += rolled;
      off_count    += e.out_of_range;
      expected_words.push_back(e);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_words.delete();
         row_at = '0;
         col_at = '0;
         for (int i = 0; i < CELLS; i++)
            screen[i] = '0;
      end else begin
         // A word shown now belongs to an earlier request, so compare first.
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               report("word with nothing expected", rsp_word, '0);
            end else begin
               want = expected_words.pop_front();
               checked_count++;
               if (rsp_word.cell_value !== want.cell_value)
                  report("cell_value", rsp_word.cell_value, want.cell_value);
               if (rsp_word.cur_row !== want.cur_row)
                  report("cur_row", rsp_word.cur_row, want.cur_row);
               if (rsp_word.cur_col !== want.cur_col)
                  report("cur_col", rsp_word.cur_col, want.cur_col);
               if (rsp_word.out_of_range !== want.out_of_range)
                  report("out_of_range", rsp_word.out_of_range, want.out_of_range);
               if (rsp_word.scrolled !== want.scrolled)
                  report("scrolled", rsp_word.scrolled, want.scrolled);
            end
         end
         if (start && !busy)
            predict_word(req_word);
      end
      failures   <= fail_count;
      pending    <= expected_words.size();
      checked    <= checked_count;
      scrolls    <= scroll_count;
      off_screen <= off_count;
   end

endmodule

// ===== tb/tb.sv =====
// tb: top of the text console writer bench. Makes clock, reset and request
// words, and gives the verdict. Depends on tcw_pkg, tcw_checker and the block.

module tb;

   import tcw_pkg::*;

   // Word budget for the random part; the three idle phases split it in thirds.
   localparam int RANDOM_WORDS = 950;
   // Worst case: every word a full-screen walk plus a sender gap, several times over.
   localparam int LIMIT = 3 * (RANDOM_WORDS + 150) * (CELLS + 40);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_word;

   int failures, pending, checked, scrolls, off_screen;
   int sent = 0;
   int idle_pct = 25;
   int cycle_count = 0;

   always #6 clock = ~clock;

   text_console_writer dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   tcw_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .failures   (failures),
      .pending    (pending),
      .checked    (checked),
      .scrolls    (scrolls),
      .off_screen (off_screen)
   );

   // Watchdog: drop the run if it overruns the generous cycle budget.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one word and hold it until the block takes it. Keep start high when
   // no gap follows, so the next word goes out back to back; otherwise lower
   // start and idle for a random stretch.
   task automatic send_word(input op_type op, input logic [7:0] ch,
                            input logic [7:0] row, input logic [7:0] col);
      int gap;
      start    <= 1'b1;
      req_word <= '{operation: op, char_code: ch, target_row: row, target_col: col};
      do @(posedge clock); while (busy);
      sent++;
      gap = 0;
      while ($urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Pick a row or column: inside the screen, or anywhere above its edge.
   function automatic logic [7:0] pick_coord(input int span, input bit off);
      return off ? 8'($urandom_range(255, span)) : 8'($urandom_range(span - 1));
   endfunction

   initial begin
      int      kind;
      int      run;
      int      which_off;
      logic [7:0] ch;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed words. Off-screen reads never touch the store, and one put is
      // read back, before anything else is read ahead of the first clear.
      send_word(OP_READ, 8'h00, 8'hFF, 8'hFF);
      send_word(OP_READ, 8'h00, 8'(ROWS), 8'h00);
      send_word(OP_PUT, 8'h5A, 8'd3, 8'd3);
      send_word(OP_READ, 8'h00, 8'd3, 8'd3);
      send_word(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
      send_word(OP_READ, 8'h00, 8'h00, 8'h00);
      send_word(OP_READ, 8'h00, 8'(ROWS - 1), 8'(COLS - 1));
      // Corner puts, a stored newline byte, and puts just off each edge.
      send_word(OP_PUT, 8'hFF, 8'h00, 8'h00);
      send_word(OP_PUT, 8'h00, 8'(ROWS - 1), 8'(COLS - 1));
      send_word(OP_PUT, NEWLINE, 8'd1, 8'd1);
      send_word(OP_PUT, 8'h41, 8'(ROWS), 8'(COLS - 1));
      send_word(OP_PUT, 8'h41, 8'(ROWS - 1), 8'(COLS));
      send_word(OP_PUT, 8'h41, 8'hFF, 8'hFF);
      send_word(OP_READ, 8'h00, 8'h00, 8'h00);
      send_word(OP_READ, 8'h00, 8'(ROWS - 1), 8'(COLS - 1));
      send_word(OP_READ, 8'h00, 8'd1, 8'd1);
      send_word(OP_READ, 8'h00, 8'h00, 8'(COLS));
      // Stream a character, a newline and both byte extremes at the cursor.
      send_word(OP_STREAM, 8'h41, 8'h00, 8'h00);
      send_word(OP_STREAM, NEWLINE, 8'hFF, 8'hFF);
      send_word(OP_STREAM, 8'hFF, 8'h00, 8'h00);
      send_word(OP_STREAM, 8'h00, 8'hFF, 8'hFF);
      send_word(OP_READ, 8'h00, 8'h00, 8'h00);
      send_word(OP_READ, 8'h00, 8'd1, 8'h00);
      send_word(OP_READ, 8'h00, 8'd1, 8'd1);

      // Random part, in bursts. Long text runs wrap rows and, on the bottom
      // row, scroll; newline runs scroll quickly; put and read runs probe the
      // store, now and then off screen; a clear comes rarely as each costs a
      // full-screen walk. Switch the sender's idle share by thirds.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         idle_pct = (sent < RANDOM_WORDS / 3) ? 25 : (sent < 2 * RANDOM_WORDS / 3) ? 58 : 0;
         kind = $urandom_range(99);
         if (kind < 45) begin
            run = $urandom_range(90, 1);
            repeat (run) begin
               ch = 8'($urandom_range(255));
               if ($urandom_range(99) < 5)
                  ch = NEWLINE;
               send_word(OP_STREAM, ch, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
         end else if (kind < 57) begin
            run = $urandom_range(8, 1);
            repeat (run)
               send_word(OP_STREAM, NEWLINE, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
         end else if (kind < 96) begin
            run = $urandom_range(6, 1);
            repeat (run) begin
               // Mostly on screen; otherwise off by row, by column or by both.
               which_off = ($urandom_range(99) < 15) ? $urandom_range(3, 1) : 0;
               send_word((kind < 72) ? OP_PUT : OP_READ, 8'($urandom_range(255)),
                         pick_coord(ROWS, which_off[0]), pick_coord(COLS, which_off[1]));
            end
         end else begin
            send_word(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
         end
      end
      start <= 1'b0;

      // Let the checker see the last request, drain the expected words, then
      // wait a little longer for any stray word.
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Checked %0d result words over three sender idle phases", checked);
      $display("Run saw %0d scrolls and %0d off-screen puts or reads", scrolls, off_screen);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
